### src/frame_feature_statistics_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef FRAME_FEATURE_STATISTICS_MACROS_SVH
`define FRAME_FEATURE_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ffs_pkg.sv
package ffs_pkg;

	// Default geometry
	localparam int COEFFS_DEF     = 13;
	localparam int MAX_FRAMES_DEF = 16;

	// Field widths
	localparam int COEFF_W = 16;
	localparam int FEAT_W  = 18;
	localparam int CFG_W   = 5;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Register map
	localparam logic       REG_FRAME_COUNT   = 1'b0;
	localparam logic [4:0] FRAME_COUNT_RESET = 5'd14;

	// Saturation limits of the Q17.0 (signed 18-bit integer) result
	localparam logic [FEAT_W-1:0] FEAT_MAX = 18'h1FFFF;
	localparam logic [FEAT_W-1:0] FEAT_MIN = 18'h20000;

	// Statistic codes
	localparam logic [1:0] STAT_MEAN  = 2'd0;
	localparam logic [1:0] STAT_STD   = 2'd1;
	localparam logic [1:0] STAT_DELTA = 2'd2;
	localparam logic [1:0] STAT_MAXM  = 2'd3;

endpackage

### src/frame_feature_statistics.sv
// Input: one coefficient transfer per cycle while the four-entry queue has room;
// the back end drains the queue at one store write per cycle while it is loading a window.
// After the last value of a window the back end computes the statistics of each coefficient in turn
// (n frames; one shared bit-serial divider, a two-bit-per-cycle root unit), then
// emits 4*COEFFS results, each held until taken; meanwhile up to four transfers queue, then stall.
// Reset clears control state and sets frame_count to 14; the store is not cleared.
module frame_feature_statistics #(
	parameter int COEFFS     = ffs_pkg::COEFFS_DEF,
	parameter int MAX_FRAMES = ffs_pkg::MAX_FRAMES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ffs_pkg::APB_AW-1:0]         paddr,
	input  logic [ffs_pkg::APB_DW-1:0]         pwdata,
	output logic [ffs_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ffs_pkg::COEFF_W-1:0] coefficient,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [3:0]                         coeff_index,
	output logic [1:0]                         statistic,
	output logic signed [ffs_pkg::FEAT_W-1:0]  feature_value,
	output logic                               last_feature
);
	import ffs_pkg::*;

	localparam int AW = $clog2(COEFFS * MAX_FRAMES);
	localparam int NW = $clog2(MAX_FRAMES + 1);
	localparam int IW = COEFF_W + AW + 1 + NW;

	logic [CFG_W-1:0] frame_count_q;
	logic             cfg_wr;
	logic [NW-1:0]    frames;

	logic                      push;
	logic                      fifo_full;
	logic                      fifo_empty;
	logic                      pop;
	logic signed [COEFF_W-1:0] f_value;
	logic [AW-1:0]             f_addr;
	logic                      f_last;
	logic [NW-1:0]             f_n;
	logic [IW-1:0]             q_wdata;
	logic [IW-1:0]             q_rdata;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT);
	assign prdata = (paddr[2] == REG_FRAME_COUNT) ? APB_DW'(frame_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
		end else if (cfg_wr) begin
			frame_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// Clamp the frame count to 1..MAX_FRAMES
	always_comb begin
		if (frame_count_q == '0) begin
			frames = NW'(1);
		end else if (int'(frame_count_q) > MAX_FRAMES) begin
			frames = NW'(MAX_FRAMES);
		end else begin
			frames = NW'(frame_count_q);
		end
	end

	ffs_front #(.COEFFS(COEFFS), .MAX_FRAMES(MAX_FRAMES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.frames      (frames),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coefficient (coefficient),
		.fifo_full   (fifo_full),
		.push        (push),
		.item_value  (f_value),
		.item_addr   (f_addr),
		.item_last   (f_last),
		.item_n      (f_n)
	);

	assign q_wdata = {f_value, f_addr, f_last, f_n};

	ffs_fifo #(.WIDTH(IW), .DEPTH(4)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (fifo_full),
		.pop    (pop),
		.empty  (fifo_empty),
		.rdata  (q_rdata)
	);

	ffs_back #(.COEFFS(COEFFS), .MAX_FRAMES(MAX_FRAMES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (!fifo_empty),
		.item_pop      (pop),
		.item_value    (q_rdata[IW-1 -: COEFF_W]),
		.item_addr     (q_rdata[NW+1 +: AW]),
		.item_last     (q_rdata[NW]),
		.item_n        (q_rdata[NW-1:0]),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.coeff_index   (coeff_index),
		.statistic     (statistic),
		.feature_value (feature_value),
		.last_feature  (last_feature)
	);
endmodule

### src/ffs_fifo.sv
module ffs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### src/ffs_front.sv
module ffs_front #(
	parameter int COEFFS     = 13,
	parameter int MAX_FRAMES = 16,
	localparam int CW = (COEFFS > 1) ? $clog2(COEFFS) : 1,
	localparam int AW = $clog2(COEFFS * MAX_FRAMES),
	localparam int NW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr,
	input  logic [NW-1:0]                     frames,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ffs_pkg::COEFF_W-1:0] coefficient,
	input  logic                              fifo_full,
	output logic                              push,
	output logic signed [ffs_pkg::COEFF_W-1:0] item_value,
	output logic [AW-1:0]                     item_addr,
	output logic                              item_last,
	output logic [NW-1:0]                     item_n
);
	import ffs_pkg::*;

	logic [CW-1:0] coeff_pos_q;
	logic [NW-1:0] frame_pos_q;
	logic [AW-1:0] addr_q;
	logic          coeff_end;
	logic          frame_end;

	assign in_ready   = !fifo_full;
	assign push       = in_valid && in_ready;
	assign coeff_end  = (coeff_pos_q == CW'(COEFFS - 1));
	assign frame_end  = (frame_pos_q == frames - NW'(1));
	assign item_value = coefficient;
	assign item_addr  = addr_q;
	assign item_last  = coeff_end && frame_end;
	assign item_n     = frames;

	// Track the store position of the next transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_pos_q <= '0;
			frame_pos_q <= '0;
			addr_q      <= '0;
		end else if (cfg_wr) begin
			coeff_pos_q <= '0;
			frame_pos_q <= '0;
			addr_q      <= '0;
		end else if (push) begin
			if (coeff_end) begin
				coeff_pos_q <= '0;
				if (frame_end) begin
					frame_pos_q <= '0;
					addr_q      <= '0;
				end else begin
					frame_pos_q <= frame_pos_q + 1'b1;
					addr_q      <= addr_q + 1'b1;
				end
			end else begin
				coeff_pos_q <= coeff_pos_q + 1'b1;
				addr_q      <= addr_q + 1'b1;
			end
		end
	end
endmodule

### src/ffs_back.sv
module ffs_back #(
	parameter int COEFFS     = 13,
	parameter int MAX_FRAMES = 16,
	localparam int CW = (COEFFS > 1) ? $clog2(COEFFS) : 1,
	localparam int AW = $clog2(COEFFS * MAX_FRAMES),
	localparam int NW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_pop,
	input  logic signed [ffs_pkg::COEFF_W-1:0] item_value,
	input  logic [AW-1:0]                     item_addr,
	input  logic                              item_last,
	input  logic [NW-1:0]                     item_n,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        coeff_index,
	output logic [1:0]                        statistic,
	output logic signed [ffs_pkg::FEAT_W-1:0] feature_value,
	output logic                              last_feature
);
	import ffs_pkg::*;

	localparam int SW  = 17 + NW;
	localparam int QW  = 31 + NW;
	localparam int DW  = QW + NW;
	localparam int RW  = DW + 3;
	localparam int RH  = RW / 2;
	localparam int XW  = 19 + NW;
	localparam int DVW = NW + 2;
	localparam int DSW = 16 + NW;
	localparam int KW  = $clog2(XW + 1);

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_ACC   = 4'd3;
	localparam logic [3:0] ST_PA    = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_WR    = 4'd6;
	localparam logic [3:0] ST_PB    = 4'd7;
	localparam logic [3:0] ST_SD    = 4'd8;
	localparam logic [3:0] ST_SQRT  = 4'd9;
	localparam logic [3:0] ST_PM    = 4'd10;
	localparam logic [3:0] ST_PM2   = 4'd11;
	localparam logic [3:0] ST_NEXT  = 4'd12;
	localparam logic [3:0] ST_EM_RD = 4'd13;
	localparam logic [3:0] ST_EM_LD = 4'd14;
	localparam logic [3:0] ST_EM_WT = 4'd15;

	logic [3:0] state_q;

	// Frame store and result store
	logic signed [COEFF_W-1:0] store_mem [COEFFS * MAX_FRAMES];
	logic signed [COEFF_W-1:0] rdata_q;
	logic [AW-1:0]             raddr_q;
	logic [FEAT_W-1:0]         res_mem [4 * (2 ** CW)];
	logic [FEAT_W-1:0]         res_rdata_q;
	logic [FEAT_W-1:0]         res_wdata;

	// Sequencer counters
	logic [NW-1:0] n_q;
	logic [CW-1:0] c_q;
	logic [NW-1:0] f_q;
	logic [1:0]    es_q;
	logic [CW-1:0] ec_q;

	// Accumulators
	logic signed [COEFF_W-1:0] x_q;
	logic [30:0]               sq_q;
	logic signed [SW-1:0]      sum_q;
	logic [QW-1:0]             sumsq_q;
	logic signed [COEFF_W-1:0] mx_q;
	logic signed [COEFF_W-1:0] prev_q;
	logic [DSW-1:0]            dsum_q;

	// Products
	logic [DW-1:0]          prod_a_q;
	logic [2*SW-1:0]        prod_b_q;
	logic signed [SW-1:0]   pm_q;

	// Divider and root unit
	logic [XW-1:0]  dnum_q;
	logic [DVW-1:0] dden_q;
	logic [DVW-1:0] drem_q;
	logic           dneg_q;
	logic [1:0]     stat_q;
	logic [KW-1:0]  k_q;
	logic [RW-1:0]  sx_q;
	logic [RH-1:0]  root_q;
	logic [RH:0]    srem_q;

	// Output register
	logic                     out_valid_q;
	logic [3:0]               coeff_index_q;
	logic [1:0]               statistic_q;
	logic [FEAT_W-1:0]        feature_q;
	logic                     last_q;

	// Combinational helpers
	logic signed [31:0]      sq_full;
	logic signed [16:0]      dif;
	logic [16:0]             dif_abs;
	logic [DW-1:0]           pa;
	logic signed [2*SW-1:0]  pb;
	logic signed [SW-1:0]    pm;
	logic [SW-1:0]           sum_mag;
	logic signed [SW-1:0]    mm_diff;
	logic [DVW:0]            dsh;
	logic [RH+2:0]           ssh;
	logic [RH+2:0]           strial;
	logic                    emit_last;

	assign item_pop = (state_q == ST_LOAD) && item_valid;

	always_comb begin
		sq_full = rdata_q * rdata_q;
		dif     = 17'(x_q) - 17'(prev_q);
		dif_abs = dif[16] ? 17'(-dif) : 17'(dif);
		pa      = DW'(n_q) * DW'(sumsq_q);
		pb      = sum_q * sum_q;
		pm      = $signed({1'b0, n_q}) * mx_q;
		sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
		mm_diff = pm_q - sum_q;
		dsh     = {drem_q, dnum_q[XW-1]};
		ssh     = {srem_q, sx_q[RW-1:RW-2]};
		strial  = {1'b0, root_q, 2'b01};
		emit_last = (es_q == STAT_MAXM) && (ec_q == CW'(COEFFS - 1));
	end

	// Put the quotient's sign back in and saturate
	always_comb begin
		if (dneg_q) begin
			res_wdata = (dnum_q > XW'(131072)) ? FEAT_MIN : FEAT_W'(-dnum_q);
		end else begin
			res_wdata = (dnum_q > XW'(131071)) ? FEAT_MAX : FEAT_W'(dnum_q);
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (item_pop) begin
			store_mem[item_addr] <= item_value;
		end
		rdata_q <= store_mem[raddr_q];
	end

	// Result store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			res_mem[{stat_q, c_q}] <= res_wdata;
		end
		res_rdata_q <= res_mem[{es_q, ec_q}];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				x_q  <= rdata_q;
				sq_q <= 31'(sq_full);
			end
			ST_ACC: begin
				prev_q <= x_q;
				if (f_q == '0) begin
					sum_q   <= SW'(x_q);
					sumsq_q <= QW'(sq_q);
					mx_q    <= x_q;
					dsum_q  <= '0;
				end else begin
					sum_q   <= sum_q + SW'(x_q);
					sumsq_q <= sumsq_q + QW'(sq_q);
					if (x_q > mx_q) begin
						mx_q <= x_q;
					end
					dsum_q  <= dsum_q + DSW'(dif_abs);
				end
			end
			ST_PA: begin
				prod_a_q <= pa;
				dnum_q   <= XW'({sum_mag, 1'b0}) + XW'(n_q);
				dden_q   <= DVW'({n_q, 1'b0});
				dneg_q   <= sum_q[SW-1];
				drem_q   <= '0;
				stat_q   <= STAT_MEAN;
			end
			ST_DIV: begin
				if (dsh >= {1'b0, dden_q}) begin
					drem_q <= DVW'(dsh - {1'b0, dden_q});
					dnum_q <= {dnum_q[XW-2:0], 1'b1};
				end else begin
					drem_q <= DVW'(dsh);
					dnum_q <= {dnum_q[XW-2:0], 1'b0};
				end
			end
			ST_WR: begin
				// Start the mean absolute delta right after the deviation
				if (stat_q == STAT_STD) begin
					dnum_q <= XW'({dsum_q, 1'b0}) + XW'(n_q - NW'(1));
					dden_q <= (n_q == NW'(1)) ? DVW'(2) : DVW'({n_q - NW'(1), 1'b0});
					dneg_q <= 1'b0;
					drem_q <= '0;
					stat_q <= STAT_DELTA;
				end
			end
			ST_PB: begin
				prod_b_q <= (2*SW)'(pb);
			end
			ST_SD: begin
				sx_q   <= RW'({prod_a_q - prod_b_q[DW-1:0], 2'b00});
				root_q <= '0;
				srem_q <= '0;
			end
			ST_SQRT: begin
				if (k_q == KW'(RH)) begin
					dnum_q <= XW'(root_q) + XW'(n_q);
					dden_q <= DVW'({n_q, 1'b0});
					dneg_q <= 1'b0;
					drem_q <= '0;
					stat_q <= STAT_STD;
				end else begin
					sx_q <= {sx_q[RW-3:0], 2'b00};
					if (ssh >= strial) begin
						srem_q <= (RH+1)'(ssh - strial);
						root_q <= {root_q[RH-2:0], 1'b1};
					end else begin
						srem_q <= (RH+1)'(ssh);
						root_q <= {root_q[RH-2:0], 1'b0};
					end
				end
			end
			ST_PM: begin
				pm_q <= pm;
			end
			ST_PM2: begin
				dnum_q <= XW'({mm_diff, 1'b0}) + XW'(n_q);
				dden_q <= DVW'({n_q, 1'b0});
				dneg_q <= 1'b0;
				drem_q <= '0;
				stat_q <= STAT_MAXM;
			end
			ST_EM_LD: begin
				coeff_index_q <= 4'(ec_q);
				statistic_q   <= es_q;
				feature_q     <= res_rdata_q;
				last_q        <= emit_last;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			n_q         <= '0;
			c_q         <= '0;
			f_q         <= '0;
			raddr_q     <= '0;
			k_q         <= '0;
			es_q        <= '0;
			ec_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_pop && item_last) begin
						n_q     <= item_n;
						c_q     <= '0;
						f_q     <= '0;
						raddr_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (f_q == n_q - NW'(1)) begin
						state_q <= ST_PA;
					end else begin
						f_q     <= f_q + 1'b1;
						raddr_q <= raddr_q + AW'(COEFFS);
						state_q <= ST_RD;
					end
				end
				ST_PA: begin
					k_q     <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					k_q <= k_q + 1'b1;
					if (k_q == KW'(XW - 1)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					k_q <= '0;
					case (stat_q)
						STAT_MEAN:  state_q <= ST_PB;
						STAT_STD:   state_q <= ST_DIV;
						STAT_DELTA: state_q <= ST_PM;
						default:    state_q <= ST_NEXT;
					endcase
				end
				ST_PB: state_q <= ST_SD;
				ST_SD: begin
					k_q     <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (k_q == KW'(RH)) begin
						k_q     <= '0;
						state_q <= ST_DIV;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_PM: state_q <= ST_PM2;
				ST_PM2: begin
					k_q     <= '0;
					state_q <= ST_DIV;
				end
				ST_NEXT: begin
					f_q <= '0;
					if (c_q == CW'(COEFFS - 1)) begin
						es_q    <= STAT_MEAN;
						ec_q    <= '0;
						state_q <= ST_EM_RD;
					end else begin
						c_q     <= c_q + 1'b1;
						raddr_q <= AW'(c_q) + AW'(1);
						state_q <= ST_RD;
					end
				end
				ST_EM_RD: state_q <= ST_EM_LD;
				ST_EM_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EM_WT;
				end
				ST_EM_WT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (emit_last) begin
							state_q <= ST_LOAD;
						end else begin
							if (ec_q == CW'(COEFFS - 1)) begin
								ec_q <= '0;
								es_q <= es_q + 1'b1;
							end else begin
								ec_q <= ec_q + 1'b1;
							end
							state_q <= ST_EM_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign coeff_index   = coeff_index_q;
	assign statistic     = statistic_q;
	assign feature_value = feature_q;
	assign last_feature  = last_q;
endmodule

### src/ffs_checker.sv
`include "frame_feature_statistics_macros.svh"

module ffs_checker #(
	parameter int COEFFS = ffs_pkg::COEFFS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [3:0]                        coeff_index,
	input logic [1:0]                        statistic,
	input logic [ffs_pkg::FEAT_W-1:0]        feature_value,
	input logic                              last_feature
);
	import ffs_pkg::*;

	`FFS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(feature_value) && $stable(statistic), "result changed while stalled")
	`FFS_ASSERT_IMP(a_last_pos, out_valid && last_feature, statistic == STAT_MAXM && coeff_index == 4'(COEFFS - 1), "last flag on wrong result")
	`FFS_ASSERT_IMP(a_nonneg, out_valid && (statistic == STAT_STD || statistic == STAT_DELTA || statistic == STAT_MAXM), !feature_value[FEAT_W-1], "negative spread statistic")
	`FFS_ASSERT_NXT(a_gap, out_valid && out_ready, !out_valid, "result stayed valid after transfer")
endmodule

bind frame_feature_statistics ffs_checker #(.COEFFS(COEFFS)) u_ffs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.coeff_index   (coeff_index),
	.statistic     (statistic),
	.feature_value (feature_value),
	.last_feature  (last_feature)
);

### tb/tb_frame_feature_statistics.sv
module tb_frame_feature_statistics;
	import ffs_pkg::*;

	localparam int NCOEF = COEFFS_DEF;
	localparam int NFRM  = MAX_FRAMES_DEF;
	localparam int FEAT_HI = 131071;
	localparam int FEAT_LO = -131072;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [3:0]        idx;
		logic [1:0]        stat;
		logic [FEAT_W-1:0] val;
		logic              last;
	} feature_t;

	// Window predictor and queue of expected features
	class feature_scoreboard;
		int unsigned frames_cfg;
		int unsigned frm_pos, coef_pos;
		logic signed [COEFF_W-1:0] window [NCOEF*NFRM];
		feature_t pending [$];
		int errors;

		function new();
			frames_cfg = FRAME_COUNT_RESET;
			frm_pos = 0;
			coef_pos = 0;
			errors = 0;
		endfunction

		function void set_frames(int unsigned v);
			frames_cfg = v & 5'h1F;
			frm_pos = 0;
			coef_pos = 0;
		endfunction

		function int unsigned depth();
			if (frames_cfg == 0) return 1;
			if (frames_cfg > NFRM) return NFRM;
			return frames_cfg;
		endfunction

		function longint div_nearest(longint num, longint den);
			if (num >= 0) return (2 * num + den) / (2 * den);
			return -((2 * (-num) + den) / (2 * den));
		endfunction

		function longint int_sqrt(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void push(int unsigned c, logic [1:0] s, longint v, logic lst);
			feature_t f;
			if (v > FEAT_HI) v = FEAT_HI;
			if (v < FEAT_LO) v = FEAT_LO;
			f.idx = c[3:0];
			f.stat = s;
			f.val = v[FEAT_W-1:0];
			f.last = lst;
			pending.push_back(f);
		endfunction

		// Store one coefficient; a completed window queues all features
		function void note_coefficient(logic signed [COEFF_W-1:0] x);
			int unsigned n;
			longint sum [NCOEF], sq [NCOEF], ds [NCOEF], mx [NCOEF];
			longint v, nn;
			n = depth();
			window[frm_pos * NCOEF + coef_pos] = x;
			coef_pos++;
			if (coef_pos < NCOEF) return;
			coef_pos = 0;
			frm_pos++;
			if (frm_pos < n) return;
			frm_pos = 0;
			nn = n;
			for (int c = 0; c < NCOEF; c++) begin
				sum[c] = 0; sq[c] = 0; ds[c] = 0;
				mx[c] = window[c];
				for (int f = 0; f < n; f++) begin
					v = window[f * NCOEF + c];
					sum[c] += v;
					sq[c] += v * v;
					if (v > mx[c]) mx[c] = v;
					if (f > 0) begin
						v = v - window[(f - 1) * NCOEF + c];
						ds[c] += (v < 0) ? -v : v;
					end
				end
			end
			for (int c = 0; c < NCOEF; c++)
				push(c, STAT_MEAN, div_nearest(sum[c], nn), 1'b0);
			for (int c = 0; c < NCOEF; c++)
				push(c, STAT_STD,
					(int_sqrt(4 * (nn * sq[c] - sum[c] * sum[c])) + nn) / (2 * nn), 1'b0);
			for (int c = 0; c < NCOEF; c++)
				push(c, STAT_DELTA, (n > 1) ? div_nearest(ds[c], nn - 1) : 0, 1'b0);
			for (int c = 0; c < NCOEF; c++)
				push(c, STAT_MAXM, div_nearest(nn * mx[c] - sum[c], nn), c == NCOEF - 1);
		endfunction

		function void check_feature(feature_t got);
			feature_t w;
			if (pending.size() == 0) begin
				$error("unexpected feature idx=%0d stat=%0d", got.idx, got.stat);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.idx !== w.idx) begin
				$error("coeff_index exp %0d got %0d", w.idx, got.idx); errors++;
			end
			if (got.stat !== w.stat) begin
				$error("statistic exp %0d got %0d", w.stat, got.stat); errors++;
			end
			if (got.val !== w.val) begin
				$error("feature_value exp %0d got %0d", $signed(w.val), $signed(got.val));
				errors++;
			end
			if (got.last !== w.last) begin
				$error("last_feature exp %0d got %0d", w.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COEFF_W-1:0] coefficient = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] coeff_index;
	logic [1:0] statistic;
	logic signed [FEAT_W-1:0] feature_value;
	logic last_feature;

	feature_scoreboard sb = new();
	longint cycles = 0;
	int stall_long = 0;
	bit rx_steady = 0;

	frame_feature_statistics u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort on runaway
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_feature({coeff_index, statistic, feature_value, last_feature});
	end

	// Receiver: random wait per result, one long hold-off
	initial begin
		int w;
		forever begin
			if (stall_long > 0) begin
				out_ready <= 1'b0;
				repeat (stall_long) @(posedge clk);
				stall_long = 0;
			end
			w = rx_steady ? 0 : $urandom_range(0, 16);
			if (w != 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_frames(int unsigned v);
		in_valid <= 1'b0;
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= APB_AW'(4 * REG_FRAME_COUNT); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_frames(v);
	endtask

	task automatic send(logic signed [COEFF_W-1:0] x, bit gaps);
		int g;
		g = gaps ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= x;
		do @(posedge clk); while (!in_ready);
		sb.note_coefficient(x);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	function automatic logic signed [COEFF_W-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return COEFF_W'(int'($urandom_range(0, 64)) - 32);
			default: return COEFF_W'($urandom());
		endcase
	endfunction

	task automatic run_window(int unsigned frames, int kind, bit gaps);
		for (int i = 0; i < frames * NCOEF; i++) begin
			case (kind)
				0: send(16'sh7FFF, gaps);
				1: send(16'sh8000, gaps);
				2: send((i / NCOEF) % 2 ? 16'sh7FFF : 16'sh8000, gaps);
				default: send(rand_coef(), gaps);
			endcase
		end
	endtask

	initial begin
		int fc;
		int total;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset depth, partial window restart, extremes
		run_window(FRAME_COUNT_RESET, 3, 1);
		drain();
		write_frames(1);
		run_window(1, 0, 0);
		run_window(1, 1, 0);
		drain();
		for (int i = 0; i < 5; i++) send(rand_coef(), 0);
		write_frames(2);

		// Fill-up: receiver held off while the next window is offered
		stall_long = 600;
		run_window(2, 2, 0);
		run_window(2, 3, 0);
		drain();
		write_frames(0);
		run_window(1, 3, 1);
		drain();

		// Frame count above the store depth
		write_frames(31);
		run_window(16, 3, 1);
		drain();

		// Random windows, short
		total = 0;
		while (total < 40) begin
			fc = $urandom_range(0, 4);
			write_frames(fc);
			rx_steady = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < 2; k++) begin
				run_window(sb.depth(), 3, !rx_steady);
				total += sb.depth() * NCOEF;
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### sim.f
+incdir+src
src/ffs_pkg.sv
src/ffs_fifo.sv
src/ffs_front.sv
src/ffs_back.sv
src/frame_feature_statistics.sv
src/ffs_checker.sv
tb/tb_frame_feature_statistics.sv
